// ===== rtl/sdda_pkg.sv =====
// Shared types and constants for the symmetric DDA line stepper.
`timescale 1ns / 1ps
package sdda_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_START = 2'd0,
    CFG_Y_START = 2'd1,
    CFG_X_END   = 2'd2,
    CFG_Y_END   = 2'd3
  } cfg_idx_t;

endpackage

// ===== rtl/sdda_if.sv =====
// Valid/ready channel interfaces for the line stepper's input and result items.
`timescale 1ns / 1ps
interface sdda_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sdda_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last;

  modport source (output valid, output point_x, output point_y, output last, input ready);
  modport sink (input valid, input point_x, input point_y, input last, output ready);
endinterface

// ===== rtl/symmetric_dda_line_stepper.sv =====
// Top level of the symmetric DDA line stepper.
`timescale 1ns / 1ps
// Usage: write the two endpoints through the cfg_ port (index 0 x_start, 1 y_start,
// 2 x_end, 3 y_end); a write is taken on any clock edge with cfg_we high and is
// used at the next restart. On the in_ch channel, an item with restart set latches
// the endpoints and produces the start point; each item with restart clear advances
// one step and produces the next point. A line of 2^n steps yields 2^n + 1 points,
// the final one flagged with last. Step items after the end, or before any restart,
// are accepted and produce nothing.
// A point appears on out_ch in the cycle after its input transfer. Throughput is
// one item per clock while out_ch does not stall, set by the single accumulator add
// per axis (or the setup logic on a restart) between the state and the result register.
// The result register frees itself in the same cycle that out_ch transfers, so
// in_ch.ready only drops while a point is held and the receiver stalls; nothing is
// lost or repeated. Synchronous reset clears the endpoint registers, the accumulators
// and the step count, and empties the result register; there is no clearing pass.
module symmetric_dda_line_stepper
  import sdda_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sdda_in_if.sink                      in_ch,
  sdda_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic signed [COORD_BITS-1:0] cfg_wdata
);

  // Accumulators carry COORD_BITS fractional bits plus headroom for the deltas.
  localparam int ACC_W = 2 * COORD_BITS + 2;
  localparam int SL_W  = COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] x_start, y_start, x_end, y_end;
  logic signed [ACC_W-1:0]      x_acc_init, y_acc_init, x_step_init, y_step_init;
  logic [SL_W-1:0]              steps_init;
  logic                         single;

  logic signed [ACC_W-1:0] x_acc_r, y_acc_r, x_step_r, y_step_r;
  logic signed [ACC_W-1:0] x_acc_nxt, y_acc_nxt, x_step_nxt, y_step_nxt;
  logic [SL_W-1:0]         steps_left_r, steps_left_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] point_x_r, point_y_r, point_x_nxt, point_y_nxt;
  logic                         last_r, last_nxt;

  logic in_xfer;
  logic walking;
  logic out_load;

  sdda_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (cfg_we),
    .idx     (cfg_idx_t'(cfg_idx)),
    .wdata   (cfg_wdata),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end)
  );

  sdda_setup #(.COORD_BITS(COORD_BITS), .ACC_W(ACC_W), .SL_W(SL_W)) u_setup (
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .x_acc_init (x_acc_init),
    .y_acc_init (y_acc_init),
    .x_step     (x_step_init),
    .y_step     (y_step_init),
    .steps      (steps_init),
    .single     (single)
  );

  // The result register is free when it is empty or is being drained this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign walking     = (steps_left_r != '0);
  assign out_load    = in_xfer && (in_ch.restart || walking);

  always_comb begin
    x_acc_nxt      = x_acc_r;
    y_acc_nxt      = y_acc_r;
    x_step_nxt     = x_step_r;
    y_step_nxt     = y_step_r;
    steps_left_nxt = steps_left_r;
    last_nxt       = last_r;
    if (in_xfer && in_ch.restart) begin
      x_acc_nxt      = x_acc_init;
      y_acc_nxt      = y_acc_init;
      x_step_nxt     = x_step_init;
      y_step_nxt     = y_step_init;
      steps_left_nxt = steps_init;
      last_nxt       = single;
    end else if (in_xfer && walking) begin
      x_acc_nxt      = x_acc_r + x_step_r;
      y_acc_nxt      = y_acc_r + y_step_r;
      steps_left_nxt = steps_left_r - SL_W'(1);
      last_nxt       = (steps_left_r == SL_W'(1));
    end
  end

  // The point is taken from the updated accumulators, so it leaves with the same edge.
  sdda_trunc #(.COORD_BITS(COORD_BITS), .ACC_W(ACC_W)) u_trunc_x (
    .acc   (x_acc_nxt),
    .coord (point_x_nxt)
  );

  sdda_trunc #(.COORD_BITS(COORD_BITS), .ACC_W(ACC_W)) u_trunc_y (
    .acc   (y_acc_nxt),
    .coord (point_y_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r      <= '0;
      y_acc_r      <= '0;
      x_step_r     <= '0;
      y_step_r     <= '0;
      steps_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      x_acc_r      <= x_acc_nxt;
      y_acc_r      <= y_acc_nxt;
      x_step_r     <= x_step_nxt;
      y_step_r     <= y_step_nxt;
      steps_left_r <= steps_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload only changes when a new point is loaded.
  always_ff @(posedge clk) begin
    if (out_load) begin
      point_x_r <= point_x_nxt;
      point_y_r <= point_y_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.point_x = point_x_r;
  assign out_ch.point_y = point_y_r;
  assign out_ch.last    = last_r;

`ifndef NO_ASSERTIONS
  // A line never has more than 2^COORD_BITS steps.
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_left_r <= (SL_W'(1) << COORD_BITS))
    else $error("step count exceeds the longest line");

  // Taking the final step ends the walk.
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_ch.restart && steps_left_r == SL_W'(1)) |=> (steps_left_r == '0))
    else $error("walk did not end after its final step");

  // A restart always yields a point in the next cycle.
  a_restart_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.restart) |=> out_valid_r)
    else $error("restart produced no start point");

  // Input back-pressure only comes from a held result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input stalled without a held result");
`endif

endmodule

// ===== rtl/sdda_cfg.sv =====
// Endpoint configuration registers of the line stepper.
`timescale 1ns / 1ps
module sdda_cfg
  import sdda_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  cfg_idx_t                     idx,
  input  logic signed [COORD_BITS-1:0] wdata,
  output logic signed [COORD_BITS-1:0] x_start,
  output logic signed [COORD_BITS-1:0] y_start,
  output logic signed [COORD_BITS-1:0] x_end,
  output logic signed [COORD_BITS-1:0] y_end
);

  logic signed [COORD_BITS-1:0] x_start_r, y_start_r, x_end_r, y_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r <= '0;
      y_start_r <= '0;
      x_end_r   <= '0;
      y_end_r   <= '0;
    end else if (we) begin
      case (idx)
        CFG_X_START: x_start_r <= wdata;
        CFG_Y_START: y_start_r <= wdata;
        CFG_X_END:   x_end_r   <= wdata;
        CFG_Y_END:   y_end_r   <= wdata;
        default: ;
      endcase
    end
  end

  assign x_start = x_start_r;
  assign y_start = y_start_r;
  assign x_end   = x_end_r;
  assign y_end   = y_end_r;

endmodule

// ===== rtl/sdda_setup.sv =====
// Line setup: endpoint swap, deltas, step count and fixed-point increments.
`timescale 1ns / 1ps
module sdda_setup #(
  parameter int COORD_BITS = 12,
  parameter int ACC_W      = 2 * COORD_BITS + 2,
  parameter int SL_W       = COORD_BITS + 2
) (
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic signed [ACC_W-1:0]      x_acc_init,
  output logic signed [ACC_W-1:0]      y_acc_init,
  output logic signed [ACC_W-1:0]      x_step,
  output logic signed [ACC_W-1:0]      y_step,
  output logic [SL_W-1:0]              steps,
  output logic                         single
);

  localparam int DW  = COORD_BITS + 1;
  localparam int N_W = $clog2(COORD_BITS + 2);

  logic                         swap;
  logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
  logic signed [DW-1:0]         dx, dy;
  logic [DW-1:0]                adx, ady, m;
  logic [N_W-1:0]               n;
  logic [N_W-1:0]               shamt;
  logic signed [ACC_W-1:0]      dx_ext, dy_ext;

  // Swap only when the end lies strictly below the start on both axes.
  assign swap = (x_end < x_start) && (y_end < y_start);
  assign xa   = swap ? x_end : x_start;
  assign ya   = swap ? y_end : y_start;
  assign xb   = swap ? x_start : x_end;
  assign yb   = swap ? y_start : y_end;

  assign dx  = {xb[COORD_BITS-1], xb} - {xa[COORD_BITS-1], xa};
  assign dy  = {yb[COORD_BITS-1], yb} - {ya[COORD_BITS-1], ya};
  assign adx = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
  assign ady = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);
  assign m   = (adx > ady) ? adx : ady;

  // n is the bit length of m, so 2^n is the smallest power of two above m.
  always_comb begin
    n = '0;
    for (int i = 0; i < DW; i++) begin
      if (m[i]) n = N_W'(i + 1);
    end
  end

  assign shamt  = N_W'(COORD_BITS) - n;
  assign dx_ext = ACC_W'(dx);
  assign dy_ext = ACC_W'(dy);

  assign x_acc_init = {{(ACC_W - 2 * COORD_BITS){xa[COORD_BITS-1]}}, xa, {COORD_BITS{1'b0}}};
  assign y_acc_init = {{(ACC_W - 2 * COORD_BITS){ya[COORD_BITS-1]}}, ya, {COORD_BITS{1'b0}}};
  assign x_step     = dx_ext <<< shamt;
  assign y_step     = dy_ext <<< shamt;
  assign single     = (m == '0);
  assign steps      = single ? '0 : (SL_W'(1) << n);

endmodule

// ===== rtl/sdda_trunc.sv =====
// Converts a fixed-point accumulator to an integer coordinate, truncating toward zero.
`timescale 1ns / 1ps
module sdda_trunc #(
  parameter int COORD_BITS = 12,
  parameter int ACC_W      = 2 * COORD_BITS + 2
) (
  input  logic signed [ACC_W-1:0]      acc,
  output logic signed [COORD_BITS-1:0] coord
);

  localparam int IW = ACC_W - COORD_BITS;

  logic [IW-1:0] whole;
  logic          round_up;
  logic [IW-1:0] adjusted;

  // The arithmetic shift floors; a negative value with a fraction moves up by one.
  assign whole    = acc[ACC_W-1:COORD_BITS];
  assign round_up = acc[ACC_W-1] && (acc[COORD_BITS-1:0] != '0);
  assign adjusted = whole + IW'(round_up);
  assign coord    = $signed(adjusted[COORD_BITS-1:0]);

endmodule
